// File: hw/rtl/hedu_pkg.sv
// Shared types, constants and character helpers for the HTML entity decoder.
`default_nettype none

package hedu_pkg;

    localparam int MAX_BODY_DEF = 10;
    localparam int QUEUE_DEPTH  = 2;
    localparam int NAME_COUNT   = 6;

    localparam logic [7:0] CHR_AMP  = 8'h26;
    localparam logic [7:0] CHR_SEMI = 8'h3B;
    localparam logic [7:0] CHR_HASH = 8'h23;

    // Work for the back end, one entry per input item that yields bytes.
    typedef struct packed {
        logic        do_flush;   // '&' then the body
        logic        do_semi;    // ';' after the flush
        logic        do_utf;     // code point as UTF-8
        logic        do_lit;     // one plain byte
        logic [31:0] cp;
        logic [7:0]  lit;
    } hedu_cmd_t;

    typedef enum logic [2:0] {
        BK_AMP,
        BK_BODY,
        BK_SEMI,
        BK_UTF,
        BK_LIT
    } bk_phase_t;

    function automatic logic [2:0] name_len(input logic [2:0] idx);
        logic [2:0] len;
        case (idx)
            3'd0, 3'd1: len = 3'd2;
            3'd2:       len = 3'd3;
            3'd3, 3'd4, 3'd5: len = 3'd4;
            default:    len = 3'd0;
        endcase
        return len;
    endfunction

    function automatic logic [31:0] name_code(input logic [2:0] idx);
        logic [31:0] code;
        case (idx)
            3'd0:    code = 32'h3C;
            3'd1:    code = 32'h3E;
            3'd2:    code = 32'h26;
            3'd3:    code = 32'h22;
            3'd4:    code = 32'h27;
            3'd5:    code = 32'hA0;
            default: code = 32'h0;
        endcase
        return code;
    endfunction

    // Character k of name idx: lt gt amp quot apos nbsp.
    function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [1:0] k);
        logic [31:0] txt;
        logic [7:0]  ch;
        case (idx)
            3'd0:    txt = {8'h00, 8'h00, "t", "l"};
            3'd1:    txt = {8'h00, 8'h00, "t", "g"};
            3'd2:    txt = {8'h00, "p", "m", "a"};
            3'd3:    txt = {"t", "o", "u", "q"};
            3'd4:    txt = {"s", "o", "p", "a"};
            3'd5:    txt = {"p", "s", "b", "n"};
            default: txt = 32'h0;
        endcase
        case (k)
            2'd0:    ch = txt[7:0];
            2'd1:    ch = txt[15:8];
            2'd2:    ch = txt[23:16];
            default: ch = txt[31:24];
        endcase
        return ch;
    endfunction

    // Digit value, or 16 when c is no digit of the base.
    function automatic logic [4:0] digit_of(input logic [7:0] c, input logic hex);
        logic [4:0] d;
        if (c >= "0" && c <= "9") begin
            d = 5'(c - 8'h30);
        end else if (hex && c >= "a" && c <= "f") begin
            d = 5'(c - 8'h57);
        end else if (hex && c >= "A" && c <= "F") begin
            d = 5'(c - 8'h37);
        end else begin
            d = 5'd16;
        end
        return d;
    endfunction

    function automatic logic is_body_byte(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == CHR_HASH;
    endfunction

    // Number of UTF-8 bytes minus one.
    function automatic logic [1:0] utf8_last(input logic [31:0] cp);
        logic [1:0] n;
        if (cp < 32'h80) begin
            n = 2'd0;
        end else if (cp < 32'h800) begin
            n = 2'd1;
        end else if (cp < 32'h10000) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [31:0] cp, input logic [1:0] k);
        logic [1:0] n;
        logic [1:0] sh;
        logic [5:0] six;
        logic [7:0] b;
        n  = utf8_last(cp);
        sh = n - k;
        case (sh)
            2'd0:    six = cp[5:0];
            2'd1:    six = cp[11:6];
            2'd2:    six = cp[17:12];
            default: six = 6'd0;
        endcase
        if (k == 2'd0) begin
            case (n)
                2'd0:    b = cp[7:0];
                2'd1:    b = 8'hC0 | 8'(cp >> 6);
                2'd2:    b = 8'hE0 | 8'(cp >> 12);
                default: b = 8'hF0 | 8'(cp >> 18);
            endcase
        end else begin
            b = {2'b10, six};
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hedu_front.sv
// Front end: accepts text bytes, tracks entity state and decodes bodies as they arrive.
`default_nettype none

module hedu_front import hedu_pkg::*; #(
    parameter int MAX_BODY = MAX_BODY_DEF,
    localparam int CNT_W  = $clog2(MAX_BODY + 1),
    localparam int BIDX_W = $clog2(MAX_BODY)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                in_byte,
    input  wire logic                      end_of_text,
    input  wire logic                      q_full,
    output logic                           q_push,
    output hedu_cmd_t                      q_cmd,
    output logic [MAX_BODY-1:0][7:0]       q_body,
    output logic [CNT_W-1:0]               q_cnt
);

    logic                       in_entity_reg, in_entity_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [MAX_BODY-1:0][7:0]   body_reg;
    logic                       num_reg, num_next;
    logic                       hex_reg, hex_next;
    logic                       stop_reg, stop_next;
    logic                       anyd_reg, anyd_next;
    logic [31:0]                cp_reg, cp_next;
    logic [NAME_COUNT-1:0]      match_reg, match_next;

    logic                       accept;
    logic                       store;
    logic [4:0]                 dg;
    logic                       name_hit;
    logic [31:0]                name_cp;
    logic                       code_ok;
    logic                       fresh;
    hedu_cmd_t                  cmd;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign dg       = digit_of(in_byte, hex_reg);

    always_comb
    begin
        name_hit = 1'b0;
        name_cp  = 32'h0;
        for (int i = 0; i < NAME_COUNT; i++)
        begin
            if (match_reg[i] && cnt_reg == CNT_W'(name_len(3'(i))))
            begin
                name_hit = 1'b1;
                name_cp  = name_code(3'(i));
            end
        end
        // num_reg and the name matches are current only once a body byte was seen
        code_ok = (cnt_reg != '0) && (num_reg ? anyd_reg : name_hit);
    end

    always_comb
    begin
        in_entity_next = in_entity_reg;
        cnt_next       = cnt_reg;
        num_next       = num_reg;
        hex_next       = hex_reg;
        stop_next      = stop_reg;
        anyd_next      = anyd_reg;
        cp_next        = cp_reg;
        match_next     = match_reg;
        store          = 1'b0;
        fresh          = 1'b1;
        cmd            = '0;
        cmd.lit        = in_byte;

        if (end_of_text)
        begin
            cmd.do_flush   = in_entity_reg;
            in_entity_next = 1'b0;
            cnt_next       = '0;
        end
        else
        begin
            if (in_entity_reg)
            begin
                if (in_byte == CHR_SEMI)
                begin
                    fresh          = 1'b0;
                    in_entity_next = 1'b0;
                    cnt_next       = '0;
                    if (code_ok)
                    begin
                        cmd.do_utf = 1'b1;
                        cmd.cp     = num_reg ? cp_reg : name_cp;
                    end
                    else
                    begin
                        cmd.do_flush = 1'b1;
                        cmd.do_semi  = 1'b1;
                    end
                end
                else if (is_body_byte(in_byte) && cnt_reg < CNT_W'(MAX_BODY))
                begin
                    fresh    = 1'b0;
                    store    = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    for (int i = 0; i < NAME_COUNT; i++)
                    begin
                        match_next[i] = (cnt_reg == '0 || match_reg[i]) &&
                                        (cnt_reg < CNT_W'(name_len(3'(i)))) &&
                                        (name_char(3'(i), cnt_reg[1:0]) == in_byte);
                    end
                    if (cnt_reg == '0)
                    begin
                        num_next  = (in_byte == CHR_HASH);
                        hex_next  = 1'b0;
                        stop_next = 1'b0;
                        anyd_next = 1'b0;
                        cp_next   = 32'h0;
                    end
                    else if (num_reg && !stop_reg)
                    begin
                        if (cnt_reg == CNT_W'(1) && (in_byte == "x" || in_byte == "X"))
                        begin
                            hex_next = 1'b1;
                        end
                        else if (dg[4])
                        begin
                            stop_next = 1'b1;
                        end
                        else
                        begin
                            anyd_next = 1'b1;
                            cp_next   = hex_reg ? {cp_reg[27:0], dg[3:0]}
                                                : (cp_reg << 3) + (cp_reg << 1) + 32'(dg[3:0]);
                        end
                    end
                end
                else
                begin
                    cmd.do_flush   = 1'b1;
                    in_entity_next = 1'b0;
                    cnt_next       = '0;
                end
            end
            if (fresh)
            begin
                if (in_byte == CHR_AMP)
                begin
                    in_entity_next = 1'b1;
                    cnt_next       = '0;
                end
                else
                begin
                    cmd.do_lit = 1'b1;
                end
            end
        end
    end

    assign q_push = accept && (cmd.do_flush || cmd.do_utf || cmd.do_lit);
    assign q_cmd  = cmd;
    assign q_body = body_reg;
    assign q_cnt  = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_entity_reg <= 1'b0;
            cnt_reg       <= '0;
            num_reg       <= 1'b0;
            hex_reg       <= 1'b0;
            stop_reg      <= 1'b0;
            anyd_reg      <= 1'b0;
            match_reg     <= '0;
        end
        else if (accept)
        begin
            in_entity_reg <= in_entity_next;
            cnt_reg       <= cnt_next;
            num_reg       <= num_next;
            hex_reg       <= hex_next;
            stop_reg      <= stop_next;
            anyd_reg      <= anyd_next;
            match_reg     <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cp_reg <= cp_next;
        end
        if (accept && store)
        begin
            body_reg[cnt_reg[BIDX_W-1:0]] <= in_byte;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hedu_queue.sv
// Command queue between front and back end, each entry with its body snapshot.
`default_nettype none

module hedu_queue import hedu_pkg::*; #(
    parameter int MAX_BODY = MAX_BODY_DEF,
    localparam int CNT_W = $clog2(MAX_BODY + 1),
    localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    input  wire hedu_cmd_t                 push_cmd,
    input  wire logic [MAX_BODY-1:0][7:0]  push_body,
    input  wire logic [CNT_W-1:0]          push_cnt,
    input  wire logic                      pop,
    output hedu_cmd_t                      head_cmd,
    output logic [MAX_BODY-1:0][7:0]       head_body,
    output logic [CNT_W-1:0]               head_cnt,
    output logic                           empty,
    output logic                           full
);

    hedu_cmd_t                  cmd_mem  [QUEUE_DEPTH];
    logic [MAX_BODY-1:0][7:0]   body_mem [QUEUE_DEPTH];
    logic [CNT_W-1:0]           cnt_mem  [QUEUE_DEPTH];
    logic [PTR_W-1:0]           wr_ptr_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [PTR_W:0]             count_reg;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == (PTR_W + 1)'(QUEUE_DEPTH));
    assign head_cmd  = cmd_mem[rd_ptr_reg];
    assign head_body = body_mem[rd_ptr_reg];
    assign head_cnt  = cnt_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_mem[wr_ptr_reg]  <= push_cmd;
            body_mem[wr_ptr_reg] <= push_body;
            cnt_mem[wr_ptr_reg]  <= push_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hedu_back.sv
// Back end: walks the head command byte by byte into the output register.
`default_nettype none

module hedu_back import hedu_pkg::*; #(
    parameter int MAX_BODY = MAX_BODY_DEF,
    localparam int CNT_W  = $clog2(MAX_BODY + 1),
    localparam int BIDX_W = $clog2(MAX_BODY)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire hedu_cmd_t                 head_cmd,
    input  wire logic [MAX_BODY-1:0][7:0]  head_body,
    input  wire logic [CNT_W-1:0]          head_cnt,
    input  wire logic                      empty,
    output logic                           pop,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [7:0]                     out_byte,
    output logic                           last
);

    bk_phase_t          phase_reg, phase_next;
    logic               busy_reg, busy_next;
    logic [BIDX_W-1:0]  idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_byte_reg, out_byte_next;
    logic               last_reg, last_next;

    bk_phase_t          cur_phase;
    logic [BIDX_W-1:0]  cur_idx;
    logic               fire;
    logic               done;
    logic [7:0]         cur_byte;
    bk_phase_t          after_flush;

    assign fire = !empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        if (busy_reg)
        begin
            cur_phase = phase_reg;
        end
        else if (head_cmd.do_flush)
        begin
            cur_phase = BK_AMP;
        end
        else if (head_cmd.do_utf)
        begin
            cur_phase = BK_UTF;
        end
        else
        begin
            cur_phase = BK_LIT;
        end
        cur_idx = busy_reg ? idx_reg : '0;
        after_flush = head_cmd.do_semi ? BK_SEMI : BK_LIT;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        busy_next      = busy_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        last_next      = last_reg;
        done           = 1'b0;
        cur_byte       = head_cmd.lit;
        phase_next     = cur_phase;

        unique case (cur_phase)
            BK_AMP:
            begin
                cur_byte = CHR_AMP;
                idx_next = '0;
                if (head_cnt != '0)
                begin
                    phase_next = BK_BODY;
                end
                else if (head_cmd.do_semi || head_cmd.do_lit)
                begin
                    phase_next = after_flush;
                end
                else
                begin
                    done = 1'b1;
                end
            end
            BK_BODY:
            begin
                cur_byte = head_body[cur_idx];
                if (CNT_W'(cur_idx) == head_cnt - 1'b1)
                begin
                    if (head_cmd.do_semi || head_cmd.do_lit)
                    begin
                        phase_next = after_flush;
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                end
                else
                begin
                    idx_next = cur_idx + 1'b1;
                end
            end
            BK_SEMI:
            begin
                cur_byte = CHR_SEMI;
                done     = 1'b1;
            end
            BK_UTF:
            begin
                cur_byte = utf8_byte(head_cmd.cp, cur_idx[1:0]);
                idx_next = cur_idx + 1'b1;
                done     = (cur_idx[1:0] == utf8_last(head_cmd.cp));
            end
            BK_LIT:
            begin
                cur_byte = head_cmd.lit;
                done     = 1'b1;
            end
            default:
            begin
                done = 1'b1;
            end
        endcase

        if (fire)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = cur_byte;
            last_next      = done;
            busy_next      = !done;
        end
        else
        begin
            phase_next = phase_reg;
            idx_next   = idx_reg;
        end
    end

    assign pop       = fire && done;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= BK_AMP;
            busy_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            busy_reg      <= busy_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        last_reg     <= last_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/html_entity_utf8_decoder_core.sv
// Accepted items pass through the command queue into the registered output.
// Throughput: one input byte a cycle while each item yields at most one byte and
// out_ready holds; the back end sends one output byte a cycle while out_ready holds,
// an item of N bytes holds it until all are sent, and the two-entry command queue
// stalls the input once it fills. Reset: rst_n clears entity state, queue pointers
// and output valid; the body buffer is not reset.
`default_nettype none

module html_entity_utf8_decoder_core import hedu_pkg::*; #(
    parameter int MAX_BODY = MAX_BODY_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            last
);

    localparam int CNT_W = $clog2(MAX_BODY + 1);

    logic                       q_push;
    logic                       q_pop;
    logic                       q_full;
    logic                       q_empty;
    hedu_cmd_t                  push_cmd;
    logic [MAX_BODY-1:0][7:0]   push_body;
    logic [CNT_W-1:0]           push_cnt;
    hedu_cmd_t                  head_cmd;
    logic [MAX_BODY-1:0][7:0]   head_body;
    logic [CNT_W-1:0]           head_cnt;

    hedu_front #(.MAX_BODY(MAX_BODY)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd),
        .q_body      (push_body),
        .q_cnt       (push_cnt)
    );

    hedu_queue #(.MAX_BODY(MAX_BODY)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .push_body (push_body),
        .push_cnt  (push_cnt),
        .pop       (q_pop),
        .head_cmd  (head_cmd),
        .head_body (head_body),
        .head_cnt  (head_cnt),
        .empty     (q_empty),
        .full      (q_full)
    );

    hedu_back #(.MAX_BODY(MAX_BODY)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_cmd  (head_cmd),
        .head_body (head_body),
        .head_cnt  (head_cnt),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last      (last)
    );

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("command popped from an empty queue");

    a_full_xor_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue reports full and empty together");

    a_pop_sets_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (out_valid && last))
        else $error("final byte of an item not marked last");
`endif

endmodule

`default_nettype wire
